@@ hw/rtl/audio_layer1_frame_dequantizer_unit_assert.svh @@
// Assertion macros shared by the frame dequantizer modules.
`ifndef AUDIO_LAYER1_FRAME_DEQUANTIZER_UNIT_ASSERT_SVH
`define AUDIO_LAYER1_FRAME_DEQUANTIZER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define AFDQ_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afdq assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define AFDQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afdq next-cycle assertion failed");

`endif

@@ hw/rtl/afdq_pkg.sv @@
// Types, constants and tables of the frame dequantizer.
`timescale 1ns / 1ps
package afdq_pkg;

  localparam int SUBBANDS    = 32;
  localparam int BLOCKS      = 12;
  localparam int SAMPLE_BITS = 24;

  localparam int SB_W      = 5;
  localparam int BLK_W     = 4;
  localparam int POS_W     = 7;
  localparam int BUF_W     = 64;
  localparam int HELD_W    = 7;
  localparam int ALLOC_W   = 4;
  localparam int SCIDX_W   = 6;
  localparam int SCALE_W   = 24;
  localparam int VAL_W     = 15;
  localparam int NB_W      = 5;
  localparam int K_W       = 17;
  localparam int RECIP_W   = 29;
  localparam int TT_W      = 32;
  localparam int P_W       = 57;
  localparam int RND_SHIFT = 52 - (SAMPLE_BITS - 2);
  localparam int MAG_W     = P_W - RND_SHIFT;

  // Input command codes
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_code_t;

  // How many bits the current step needs
  typedef enum logic [1:0] {
    NEED_ALLOC,
    NEED_SCALE,
    NEED_SMP
  } need_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_SC_RD,
    S_SC_EV,
    S_SM_RD,
    S_SM_EV,
    S_MUL1,
    S_MUL2,
    S_RND,
    S_SAT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic  start;
    logic  append;
    logic  alloc_take;
    logic  pos_clr;
    logic  scale_take;
    logic  scale_next;
    logic  smp_take;
    logic  smp_next;
    logic  mul1;
    logic  mul2;
    logic  rnd;
    logic  out_load;
    logic  frame_end;
    need_t need;
  } dp_cmd_t;

  typedef struct packed {
    logic have_bits;
    logic alloc_end;
    logic scale_end;
    logic scale_skip;
    logic smp_skip;
    logic smp_end;
  } dp_stat_t;

  typedef logic [63:0][SCALE_W-1:0] scale_tab_t;

  // Allocation codes 1..14 carry samples, 0 and 15 do not
  function automatic logic alloc_ok(input logic [ALLOC_W-1:0] a);
    return a inside {[4'd1:4'd14]};
  endfunction

  // round(2^30 / (2^(a+1)-1))
  function automatic logic [RECIP_W-1:0] recip(input logic [ALLOC_W-1:0] a);
    logic [RECIP_W-1:0] r;
    case (a)
      4'd1:    r = 29'd357913941;
      4'd2:    r = 29'd153391689;
      4'd3:    r = 29'd71582788;
      4'd4:    r = 29'd34636833;
      4'd5:    r = 29'd17043521;
      4'd6:    r = 29'd8454660;
      4'd7:    r = 29'd4210752;
      4'd8:    r = 29'd2101256;
      4'd9:    r = 29'd1049601;
      4'd10:   r = 29'd524544;
      4'd11:   r = 29'd262208;
      4'd12:   r = 29'd131088;
      4'd13:   r = 29'd65540;
      4'd14:   r = 29'd32769;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Scale factors 2^(1-i/3), unsigned Q.22, built at elaboration
  function automatic scale_tab_t build_scale();
    scale_tab_t t;
    logic [63:0] m;
    logic [63:0] e;
    int s;
    for (int i = 0; i < 64; i++) begin
      s = 9 + i / 3;
      case (i % 3)
        0:       m = 64'd4294967296;
        1:       m = 64'd3408917802;
        default: m = 64'd2705659852;
      endcase
      e = (m + (64'd1 << (s - 1))) >> s;
      t[i] = e[SCALE_W-1:0];
    end
    return t;
  endfunction

  localparam scale_tab_t SCALE_TABLE = build_scale();

endpackage

@@ hw/rtl/afdq_channels.sv @@
// Word channel interfaces of the frame dequantizer.
`timescale 1ns / 1ps
interface afdq_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic        stereo;
  logic [5:0]  bound;
  logic [31:0] word;
  modport source (output valid, command, stereo, bound, word, input ready);
  modport sink   (input valid, command, stereo, bound, word, output ready);
endinterface

interface afdq_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [afdq_pkg::SAMPLE_BITS-1:0]   left_sample;
  logic signed [afdq_pkg::SAMPLE_BITS-1:0]   right_sample;
  logic [4:0]                                subband;
  logic [3:0]                                block;
  logic                                      last;
  modport source (output valid, left_sample, right_sample, subband, block, last,
                  input ready);
  modport sink   (input valid, left_sample, right_sample, subband, block, last,
                  output ready);
endinterface

@@ hw/rtl/afdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module afdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ hw/rtl/afdq_ctrl.sv @@
// Frame sequencer: walks allocation, scale and sample steps.
`timescale 1ns / 1ps
module afdq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_command,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  afdq_pkg::dp_stat_t stat,
  output afdq_pkg::dp_cmd_t  cmd
);

`include "audio_layer1_frame_dequantizer_unit_assert.svh"

  afdq_pkg::state_t state_r, state_nxt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= afdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    cmd       = '0;
    cmd.need  = afdq_pkg::NEED_SMP;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    state_nxt = state_r;
    case (state_r)
      afdq_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      afdq_pkg::S_ALLOC: begin
        cmd.need = afdq_pkg::NEED_ALLOC;
        if (stat.alloc_end) begin
          cmd.pos_clr = 1'b1;
          state_nxt   = afdq_pkg::S_SC_RD;
        end else if (stat.have_bits) begin
          cmd.alloc_take = 1'b1;
        end else begin
          in_ready = 1'b1;
        end
      end
      afdq_pkg::S_SC_RD: begin
        cmd.need  = afdq_pkg::NEED_SCALE;
        state_nxt = stat.scale_end ? afdq_pkg::S_SM_RD : afdq_pkg::S_SC_EV;
      end
      afdq_pkg::S_SC_EV: begin
        cmd.need = afdq_pkg::NEED_SCALE;
        if (stat.scale_skip) begin
          cmd.scale_next = 1'b1;
          state_nxt      = afdq_pkg::S_SC_RD;
        end else if (stat.have_bits) begin
          cmd.scale_take = 1'b1;
          state_nxt      = afdq_pkg::S_SC_RD;
        end else begin
          in_ready = 1'b1;
        end
      end
      afdq_pkg::S_SM_RD: begin
        state_nxt = afdq_pkg::S_SM_EV;
      end
      afdq_pkg::S_SM_EV: begin
        if (stat.smp_skip) begin
          cmd.smp_next = 1'b1;
          if (stat.smp_end) begin
            cmd.frame_end = 1'b1;
            state_nxt     = afdq_pkg::S_IDLE;
          end else begin
            state_nxt = afdq_pkg::S_SM_RD;
          end
        end else if (stat.have_bits) begin
          cmd.smp_take = 1'b1;
          state_nxt    = afdq_pkg::S_MUL1;
        end else begin
          in_ready = 1'b1;
        end
      end
      afdq_pkg::S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = afdq_pkg::S_MUL2;
      end
      afdq_pkg::S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = afdq_pkg::S_RND;
      end
      afdq_pkg::S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = afdq_pkg::S_SAT;
      end
      afdq_pkg::S_SAT: begin
        cmd.out_load = 1'b1;
        state_nxt    = afdq_pkg::S_OUT;
      end
      afdq_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.smp_next = 1'b1;
          if (stat.smp_end) begin
            cmd.frame_end = 1'b1;
            state_nxt     = afdq_pkg::S_IDLE;
          end else begin
            state_nxt = afdq_pkg::S_SM_RD;
          end
        end
      end
      default: begin
        state_nxt = afdq_pkg::S_IDLE;
      end
    endcase

    // Input words are only taken while waiting, so nothing else runs then
    if (in_valid && in_ready) begin
      if (in_command == afdq_pkg::CMD_START) begin
        cmd.start = 1'b1;
        state_nxt = afdq_pkg::S_ALLOC;
      end else if (state_r != afdq_pkg::S_IDLE) begin
        cmd.append = 1'b1;
      end
    end
  end

  // Sample lane stages, no input taken there
  assign busy = state_r inside {afdq_pkg::S_MUL1, afdq_pkg::S_MUL2, afdq_pkg::S_RND,
                                afdq_pkg::S_SAT, afdq_pkg::S_OUT};

  `AFDQ_ASSERT(a_busy_no_in, busy, !in_ready)
  `AFDQ_ASSERT_NXT(a_start_alloc, (in_valid && in_ready && in_command == afdq_pkg::CMD_START), state_r == afdq_pkg::S_ALLOC)
  `AFDQ_ASSERT_NXT(a_load_shows, cmd.out_load, out_valid)

endmodule

@@ hw/rtl/afdq_dp.sv @@
// Datapath: bit buffer, side-info stores and the dequantizing lanes.
`timescale 1ns / 1ps
module afdq_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  afdq_pkg::dp_cmd_t                       cmd,
  output afdq_pkg::dp_stat_t                      stat,
  input  logic                                    in_stereo,
  input  logic [5:0]                              in_bound,
  input  logic [31:0]                             in_word,
  output logic signed [afdq_pkg::SAMPLE_BITS-1:0] out_left_sample,
  output logic signed [afdq_pkg::SAMPLE_BITS-1:0] out_right_sample,
  output logic [afdq_pkg::SB_W-1:0]               out_subband,
  output logic [afdq_pkg::BLK_W-1:0]              out_block,
  output logic                                    out_last
);

`include "audio_layer1_frame_dequantizer_unit_assert.svh"

  localparam int SBW = afdq_pkg::SAMPLE_BITS;

  // Control state
  logic                          stereo_r;
  logic [5:0]                    eb_r;
  logic [afdq_pkg::BUF_W-1:0]    buf_r, buf_nxt;
  logic [afdq_pkg::HELD_W-1:0]   held_r, held_nxt;
  logic [afdq_pkg::POS_W-1:0]    pos_r;
  logic [afdq_pkg::SB_W-1:0]     sb_r, last_sb_r;
  logic [afdq_pkg::BLK_W-1:0]    blk_r;

  // Store read ports
  logic [afdq_pkg::ALLOC_W-1:0]  al_rd, ar_rd;
  logic [afdq_pkg::SCIDX_W-1:0]  sl_rd, sr_rd;

  // Lane payload
  logic [afdq_pkg::VAL_W-1:0]    vl_r, vr_r;
  logic [afdq_pkg::ALLOC_W-1:0]  al_r, ar_r;
  logic [afdq_pkg::SCALE_W-1:0]  scl_r, scr_r;
  logic                          en_l_r, en_r_r, last_r;
  logic [afdq_pkg::SB_W-1:0]     sb_o_r;
  logic [afdq_pkg::BLK_W-1:0]    blk_o_r;
  logic signed [afdq_pkg::TT_W-1:0] tt_l_r, tt_r_r;
  logic signed [afdq_pkg::P_W-1:0]  p_l_r, p_r_r;
  logic [afdq_pkg::MAG_W-1:0]    mag_l_r, mag_r_r;
  logic                          neg_l_r, neg_r_r;

  // Step decode
  logic                          joint, ok_l, ok_r, shared_w, ch;
  logic [afdq_pkg::NB_W-1:0]     nl, nr, nsum, need_n;
  logic [afdq_pkg::SB_W-1:0]     a_sb, rd_sb;
  logic [afdq_pkg::ALLOC_W-1:0]  sc_a, new_a;
  logic [5:0]                    bnd;
  logic [afdq_pkg::VAL_W-1:0]    vl, vr;
  logic [afdq_pkg::BUF_W-1:0]    buf_sh_l;
  logic                          take;
  logic                          we_al, we_ar, we_sl, we_sr;

  // Products
  logic signed [afdq_pkg::K_W-1:0]      k_l, k_r;
  logic signed [afdq_pkg::RECIP_W:0]    rc_l, rc_r;
  logic signed [46:0]                   prod1_l, prod1_r;
  logic signed [afdq_pkg::P_W-1:0]      prod2_l, prod2_r;
  logic signed [afdq_pkg::SCALE_W:0]    sc_l_s, sc_r_s;

  // 2v + 2 - 2^nb, the sample offset to zero mean
  function automatic logic signed [afdq_pkg::K_W-1:0] kval(
    input logic [afdq_pkg::VAL_W-1:0]   v,
    input logic [afdq_pkg::ALLOC_W-1:0] a
  );
    logic [afdq_pkg::K_W-1:0] p2;
    logic [afdq_pkg::K_W-1:0] s;
    p2 = 17'd1 << (5'(a) + 5'd1);
    s  = {1'b0, v, 1'b0} + 17'd2 - p2;
    return $signed(s);
  endfunction

  // Rounded magnitude of a Q.52 product
  function automatic logic [afdq_pkg::MAG_W-1:0] rmag(
    input logic signed [afdq_pkg::P_W-1:0] p
  );
    logic [afdq_pkg::P_W-1:0] m;
    logic [afdq_pkg::P_W-1:0] t;
    m = p[afdq_pkg::P_W-1] ? 57'(-p) : 57'(p);
    t = (m + (57'd1 << (afdq_pkg::RND_SHIFT - 1))) >> afdq_pkg::RND_SHIFT;
    return t[afdq_pkg::MAG_W-1:0];
  endfunction

  // Clamp to the signed sample range and apply the sign
  function automatic logic [SBW-1:0] sat(
    input logic [afdq_pkg::MAG_W-1:0] m,
    input logic                       neg
  );
    logic [afdq_pkg::MAG_W-1:0] lim;
    logic [afdq_pkg::MAG_W-1:0] c;
    logic [afdq_pkg::MAG_W-1:0] n;
    lim = afdq_pkg::MAG_W'(1) << (SBW - 1);
    if (neg) begin
      c = (m > lim) ? lim : m;
      n = afdq_pkg::MAG_W'(0) - c;
      return n[SBW-1:0];
    end
    c = (m > lim - 1'b1) ? lim - 1'b1 : m;
    return c[SBW-1:0];
  endfunction

  // Side-info stores: allocation and scale, one of each per channel
  afdq_ram #(.WIDTH(afdq_pkg::ALLOC_W), .DEPTH(afdq_pkg::SUBBANDS)) u_alloc_l (
    .clk(clk), .we(we_al), .waddr(a_sb), .wdata(new_a), .raddr(rd_sb), .rdata(al_rd)
  );
  afdq_ram #(.WIDTH(afdq_pkg::ALLOC_W), .DEPTH(afdq_pkg::SUBBANDS)) u_alloc_r (
    .clk(clk), .we(we_ar), .waddr(a_sb), .wdata(new_a), .raddr(rd_sb), .rdata(ar_rd)
  );
  afdq_ram #(.WIDTH(afdq_pkg::SCIDX_W), .DEPTH(afdq_pkg::SUBBANDS)) u_scale_l (
    .clk(clk), .we(we_sl), .waddr(pos_r[5:1]), .wdata(buf_r[63:58]), .raddr(rd_sb),
    .rdata(sl_rd)
  );
  afdq_ram #(.WIDTH(afdq_pkg::SCIDX_W), .DEPTH(afdq_pkg::SUBBANDS)) u_scale_r (
    .clk(clk), .we(we_sr), .waddr(pos_r[5:1]), .wdata(buf_r[63:58]), .raddr(rd_sb),
    .rdata(sr_rd)
  );

  // Allocation write addressing: interleaved below the bound, shared above
  assign new_a    = buf_r[63:60];
  assign shared_w = pos_r >= {eb_r, 1'b0};
  assign a_sb     = shared_w ? 5'(pos_r - 7'(eb_r)) : pos_r[5:1];
  assign we_al    = cmd.alloc_take && (shared_w || !pos_r[0]);
  assign we_ar    = cmd.alloc_take && (shared_w || pos_r[0]);
  assign we_sl    = cmd.scale_take && !pos_r[0];
  assign we_sr    = cmd.scale_take && pos_r[0];
  assign rd_sb    = (cmd.need == afdq_pkg::NEED_SCALE) ? pos_r[5:1] : sb_r;

  // Scale step decode
  assign ch   = pos_r[0];
  assign sc_a = ch ? ar_rd : al_rd;

  // Sample step decode
  assign joint = {1'b0, sb_r} < eb_r;
  assign ok_l  = afdq_pkg::alloc_ok(al_rd);
  assign ok_r  = afdq_pkg::alloc_ok(ar_rd);
  assign nl    = ok_l ? 5'(al_rd) + 5'd1 : 5'd0;
  assign nr    = (joint && ok_r) ? 5'(ar_rd) + 5'd1 : 5'd0;
  assign nsum  = nl + nr;

  always_comb begin
    case (cmd.need)
      afdq_pkg::NEED_ALLOC: need_n = 5'd4;
      afdq_pkg::NEED_SCALE: need_n = 5'd6;
      afdq_pkg::NEED_SMP:   need_n = nsum;
      default:              need_n = 5'd0;
    endcase
  end

  assign stat.have_bits  = held_r >= 7'(need_n);
  assign stat.alloc_end  = pos_r == 7'(eb_r) + 7'(afdq_pkg::SUBBANDS);
  assign stat.scale_end  = pos_r == 7'(2 * afdq_pkg::SUBBANDS);
  assign stat.scale_skip = (ch && !stereo_r) || !afdq_pkg::alloc_ok(sc_a);
  assign stat.smp_skip   = nsum == 5'd0;
  assign stat.smp_end    = (blk_r == 4'(afdq_pkg::BLOCKS - 1)) &&
                           (sb_r == 5'(afdq_pkg::SUBBANDS - 1));

  // Field extraction from the head of the buffer
  assign buf_sh_l = buf_r << nl;
  assign vl       = buf_r[63:49] >> (5'd15 - nl);
  assign vr       = buf_sh_l[63:49] >> (5'd15 - nr);
  assign take     = cmd.alloc_take || cmd.scale_take || cmd.smp_take;

  // Effective bound
  assign bnd = (in_bound > 6'(afdq_pkg::SUBBANDS)) ? 6'(afdq_pkg::SUBBANDS) : in_bound;

  // Bit buffer, MSB aligned
  always_comb begin
    buf_nxt  = buf_r;
    held_nxt = held_r;
    if (cmd.start || cmd.frame_end) begin
      buf_nxt  = '0;
      held_nxt = '0;
    end else if (cmd.append) begin
      buf_nxt  = buf_r | ({in_word, 32'd0} >> held_r);
      held_nxt = held_r + 7'd32;
    end else if (take) begin
      buf_nxt  = buf_r << need_n;
      held_nxt = held_r - 7'(need_n);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r  <= 1'b0;
      eb_r      <= '0;
      buf_r     <= '0;
      held_r    <= '0;
      pos_r     <= '0;
      sb_r      <= '0;
      blk_r     <= '0;
      last_sb_r <= '0;
    end else begin
      buf_r  <= buf_nxt;
      held_r <= held_nxt;
      if (cmd.start) begin
        stereo_r  <= in_stereo;
        eb_r      <= in_stereo ? bnd : 6'd0;
        pos_r     <= '0;
        sb_r      <= '0;
        blk_r     <= '0;
        last_sb_r <= '0;
      end else begin
        if (cmd.pos_clr) begin
          pos_r <= '0;
        end else if (cmd.alloc_take || cmd.scale_take || cmd.scale_next) begin
          pos_r <= pos_r + 7'd1;
        end
        if (cmd.alloc_take && afdq_pkg::alloc_ok(new_a)) begin
          last_sb_r <= a_sb;
        end
        if (cmd.smp_next) begin
          if (sb_r == 5'(afdq_pkg::SUBBANDS - 1)) begin
            sb_r  <= '0;
            blk_r <= blk_r + 4'd1;
          end else begin
            sb_r <= sb_r + 5'd1;
          end
        end
      end
    end
  end

  // Lane arithmetic
  assign k_l     = kval(vl_r, al_r);
  assign k_r     = kval(vr_r, ar_r);
  assign rc_l    = $signed({1'b0, afdq_pkg::recip(al_r)});
  assign rc_r    = $signed({1'b0, afdq_pkg::recip(ar_r)});
  assign prod1_l = k_l * rc_l;
  assign prod1_r = k_r * rc_r;
  assign sc_l_s  = $signed({1'b0, scl_r});
  assign sc_r_s  = $signed({1'b0, scr_r});
  assign prod2_l = tt_l_r * sc_l_s;
  assign prod2_r = tt_r_r * sc_r_s;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.smp_take) begin
      vl_r    <= vl;
      vr_r    <= joint ? vr : vl;
      al_r    <= al_rd;
      ar_r    <= joint ? ar_rd : al_rd;
      scl_r   <= afdq_pkg::SCALE_TABLE[sl_rd];
      scr_r   <= afdq_pkg::SCALE_TABLE[sr_rd];
      en_l_r  <= ok_l;
      en_r_r  <= joint ? ok_r : stereo_r;
      sb_o_r  <= sb_r;
      blk_o_r <= blk_r;
      last_r  <= (blk_r == 4'(afdq_pkg::BLOCKS - 1)) && (sb_r == last_sb_r);
    end
    if (cmd.mul1) begin
      tt_l_r <= prod1_l[afdq_pkg::TT_W-1:0];
      tt_r_r <= prod1_r[afdq_pkg::TT_W-1:0];
    end
    if (cmd.mul2) begin
      p_l_r <= prod2_l;
      p_r_r <= prod2_r;
    end
    if (cmd.rnd) begin
      mag_l_r <= rmag(p_l_r);
      mag_r_r <= rmag(p_r_r);
      neg_l_r <= p_l_r[afdq_pkg::P_W-1];
      neg_r_r <= p_r_r[afdq_pkg::P_W-1];
    end
    if (cmd.out_load) begin
      out_left_sample  <= en_l_r ? $signed(sat(mag_l_r, neg_l_r)) : '0;
      out_right_sample <= en_r_r ? $signed(sat(mag_r_r, neg_r_r)) : '0;
      out_subband      <= sb_o_r;
      out_block        <= blk_o_r;
      out_last         <= last_r;
    end
  end

  `AFDQ_ASSERT(a_held_cap, 1'b1, held_r <= 7'd64)
  `AFDQ_ASSERT(a_append_room, cmd.append, held_r <= 7'd32)
  `AFDQ_ASSERT(a_take_has_bits, take, stat.have_bits)

endmodule

@@ hw/rtl/audio_layer1_frame_dequantizer_unit.sv @@
// Top level of the Layer I frame dequantizer.
`timescale 1ns / 1ps
// Usage:
// in_ch carries input words. command = start loads stereo and bound and opens a
// frame; command = data brings 32 bitstream bits, MSB first. Data words outside
// a frame are dropped. A start during a frame abandons it.
// out_ch carries one word per sample pair of an allocated subband, in stream
// order, with subband, block and a last flag on the final pair of the frame.
// Steps: an allocation field is taken straight from the buffer, a scale field
// after a store read, and a sample pair in store read, field extract, two multiply
// stages, round, clamp and hold, plus any output stall. A result is registered
// at each of these stages, and one sample pair is done before the next starts.
// in_ch.ready is high only while the sequencer waits for more bits (or idles),
// so one word at a time is in flight.
// Reset: idle, empty bit buffer; words are ignored until a start.
// Stall: a held result keeps out_ch.valid high and the block takes no input.
module audio_layer1_frame_dequantizer_unit (
  input  logic              clk,
  input  logic              rst_n,
  afdq_in_if.sink           in_ch,
  afdq_out_if.source        out_ch
);

  afdq_pkg::dp_cmd_t  cmd;
  afdq_pkg::dp_stat_t stat;

  afdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  afdq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_stereo        (in_ch.stereo),
    .in_bound         (in_ch.bound),
    .in_word          (in_ch.word),
    .out_left_sample  (out_ch.left_sample),
    .out_right_sample (out_ch.right_sample),
    .out_subband      (out_ch.subband),
    .out_block        (out_ch.block),
    .out_last         (out_ch.last)
  );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the Layer I frame dequantizer.
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
    logic [4:0]  sb;
    logic [3:0]  blk;
    logic        last;
  } pair_t;

  logic clk;
  logic rst_n;

  afdq_in_if  in_if ();
  afdq_out_if out_if ();

  audio_layer1_frame_dequantizer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Predictor state
  int          pr_phase;
  int          pr_pos;
  logic        pr_stereo;
  logic [5:0]  pr_bound;
  bit          pr_bits[$];
  logic [3:0]  pr_alloc[64];
  logic [5:0]  pr_scidx[64];
  longint      scale_q22[64];
  pair_t       pending_pairs[$];

  // Stimulus and run bookkeeping
  bit          stim_bits[$];
  int          frame_alloc_l[32];
  int          frame_alloc_r[32];
  int          words_sent;
  int          frames_sent;
  int          pairs_checked;
  int          mismatches;
  int          stall_hold;
  bit          no_idle;
  int          quiet_cycles;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Scale factors 2^(1-i/3) with 22 fraction bits
  initial begin
    longint mant;
    int sh;
    for (int i = 0; i < 64; i++) begin
      sh = 9 + i / 3;
      mant = (i % 3 == 0) ? 64'd4294967296 : (i % 3 == 1) ? 64'd3408917802 : 64'd2705659852;
      scale_q22[i] = (mant + (64'd1 << (sh - 1))) >> sh;
    end
  end

  function automatic bit alloc_valid(input logic [3:0] a);
    return a >= 4'd1 && a <= 4'd14;
  endfunction

  function automatic logic [31:0] pull_bits(input int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v = {v[30:0], pr_bits.pop_front()};
    return v;
  endfunction

  // (v*factor + offset) * scale, rounded to Q2.22 and clamped
  function automatic logic [23:0] dequantize(input logic [31:0] v, input logic [3:0] a,
                                             input logic [5:0] si);
    longint d, r, tt, p, mag;
    int nb;
    nb = a + 1;
    d = (64'sd1 <<< nb) - 1;
    r = ((64'sd1 <<< 30) + (d >>> 1)) / d;
    tt = longint'(v) * (2 * r) + (2 - (64'sd1 <<< nb)) * r;
    p = tt * scale_q22[si];
    mag = (p < 0) ? -p : p;
    mag = (mag + (64'sd1 <<< 29)) >>> 30;
    if (p < 0) begin
      if (mag > 64'sd8388608) mag = 64'sd8388608;
      mag = -mag;
    end else if (mag > 64'sd8388607) begin
      mag = 64'sd8388607;
    end
    return mag[23:0];
  endfunction

  function automatic void frame_done();
    pr_phase = 0;
    pr_pos = 0;
    pr_bits.delete();
  endfunction

  // Advance the predictor by one accepted word
  function automatic void predict_word(input logic cmd, input logic st, input logic [5:0] bd,
                                       input logic [31:0] w);
    int eb, ch, sb, blk, nl, nr;
    logic [3:0] a;
    logic [31:0] v;
    pair_t pr;
    if (cmd == afdq_pkg::CMD_START) begin
      pr_stereo = st;
      pr_bound = bd;
      pr_phase = 1;
      pr_pos = 0;
      pr_bits.delete();
      return;
    end
    if (pr_phase == 0) return;
    for (int i = 31; i >= 0; i--) pr_bits.push_back(w[i]);
    eb = (pr_bound > 32) ? 32 : pr_bound;
    if (!pr_stereo) eb = 0;
    // allocations
    if (pr_phase == 1) begin
      while (pr_pos < eb + 32) begin
        if (pr_bits.size() < 4) return;
        v = pull_bits(4);
        a = v[3:0];
        if (pr_pos < 2 * eb) begin
          pr_alloc[(pr_pos & 1) * 32 + (pr_pos >> 1)] = a;
        end else begin
          pr_alloc[pr_pos - eb] = a;
          pr_alloc[32 + pr_pos - eb] = a;
        end
        pr_pos++;
      end
      pr_phase = 2;
      pr_pos = 0;
    end
    // scale indices
    if (pr_phase == 2) begin
      while (pr_pos < 64) begin
        ch = pr_pos & 1;
        sb = pr_pos >> 1;
        if (!((ch == 1 && !pr_stereo) || !alloc_valid(pr_alloc[ch * 32 + sb]))) begin
          if (pr_bits.size() < 6) return;
          v = pull_bits(6);
          pr_scidx[ch * 32 + sb] = v[5:0];
        end
        pr_pos++;
      end
      pr_phase = 3;
      pr_pos = 0;
    end
    // samples
    while (pr_pos < 12 * 32) begin
      blk = pr_pos / 32;
      sb = pr_pos % 32;
      nl = alloc_valid(pr_alloc[sb]) ? pr_alloc[sb] + 1 : 0;
      nr = (sb < eb && alloc_valid(pr_alloc[32 + sb])) ? pr_alloc[32 + sb] + 1 : 0;
      if (nl + nr != 0) begin
        if (pr_bits.size() < nl + nr) return;
        pr.left = '0;
        pr.right = '0;
        if (sb < eb) begin
          if (nl != 0) pr.left = dequantize(pull_bits(nl), pr_alloc[sb], pr_scidx[sb]);
          if (nr != 0)
            pr.right = dequantize(pull_bits(nr), pr_alloc[32 + sb], pr_scidx[32 + sb]);
        end else begin
          v = pull_bits(nl);
          pr.left = dequantize(v, pr_alloc[sb], pr_scidx[sb]);
          if (pr_stereo) pr.right = dequantize(v, pr_alloc[sb], pr_scidx[32 + sb]);
        end
        pr.sb = 5'(sb);
        pr.blk = 4'(blk);
        pr.last = (blk == 11);
        for (int k = sb + 1; k < 32; k++)
          if (alloc_valid(pr_alloc[k]) || alloc_valid(pr_alloc[32 + k])) pr.last = 1'b0;
        pending_pairs.push_back(pr);
      end
      pr_pos++;
    end
    frame_done();
  endfunction

  // Predict on accepted input words, check accepted results
  always @(posedge clk) begin
    pair_t got, want;
    if (rst_n && in_if.valid && in_if.ready)
      predict_word(in_if.command, in_if.stereo, in_if.bound, in_if.word);
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.left_sample, out_if.right_sample, out_if.subband, out_if.block, out_if.last};
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %h", got);
      end else begin
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp L=%h R=%h sb=%0d blk=%0d last=%b, %s",
                     want.left, want.right, want.sb, want.blk, want.last,
                     $sformatf("got L=%h R=%h sb=%0d blk=%0d last=%b",
                               got.left, got.right, got.sb, got.blk, got.last));
        end
      end
    end
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 8000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    stall_hold = 0;
    forever begin
      @(posedge clk);
      if (stall_hold > 0) begin
        out_if.ready <= 1'b0;
        stall_hold--;
      end else begin
        out_if.ready <= (pick_gap() == 0);
      end
    end
  end

  // Offer one word and wait until it is taken
  task automatic send_word(input logic cmd, input logic st, input logic [5:0] bd,
                           input logic [31:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.stereo <= st;
    in_if.bound <= bd;
    in_if.word <= w;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    words_sent++;
  endtask

  task automatic push_field(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) stim_bits.push_back(v[i]);
  endtask

  // Build a frame from frame_alloc_l/r and send it; max_words < 0 sends it whole.
  // smp_fill: 0 random, 1 all ones, 2 all zeros. sc_fill: 0 random, 1 index 0, 2 index 63.
  task automatic send_frame(input logic st, input logic [5:0] bd, input int smp_fill,
                            input int sc_fill, input int max_words);
    int eb, per_block, nw;
    logic [31:0] w;
    eb = (bd > 32) ? 32 : bd;
    if (!st) eb = 0;
    stim_bits.delete();
    for (int sb = 0; sb < eb; sb++) begin
      push_field(frame_alloc_l[sb], 4);
      push_field(frame_alloc_r[sb], 4);
    end
    for (int sb = eb; sb < 32; sb++) begin
      push_field(frame_alloc_l[sb], 4);
      frame_alloc_r[sb] = frame_alloc_l[sb];
    end
    per_block = 0;
    for (int sb = 0; sb < 32; sb++)
      for (int ch = 0; ch < 2; ch++) begin
        if (ch == 1 && !st) continue;
        if (!alloc_valid(4'(ch ? frame_alloc_r[sb] : frame_alloc_l[sb]))) continue;
        push_field(sc_fill == 1 ? 0 : sc_fill == 2 ? 63 : $urandom_range(0, 63), 6);
        if (ch == 0 || sb < eb) per_block += (ch ? frame_alloc_r[sb] : frame_alloc_l[sb]) + 1;
      end
    for (int i = 0; i < 12 * per_block; i++)
      stim_bits.push_back(smp_fill == 1 ? 1'b1 : smp_fill == 2 ? 1'b0 : 1'($urandom));
    while (stim_bits.size() % 32 != 0) stim_bits.push_back(1'($urandom));
    send_word(afdq_pkg::CMD_START, st, bd, $urandom);
    frames_sent++;
    nw = stim_bits.size() / 32;
    if (max_words >= 0 && max_words < nw) nw = max_words;
    for (int i = 0; i < nw; i++) begin
      for (int b = 0; b < 32; b++) w[31 - b] = stim_bits[i * 32 + b];
      send_word(afdq_pkg::CMD_DATA, 1'($urandom), 6'($urandom), w);
    end
  endtask

  task automatic clear_alloc();
    for (int i = 0; i < 32; i++) begin
      frame_alloc_l[i] = 0;
      frame_alloc_r[i] = 0;
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Largest allocation, largest scale, full-scale and zero samples
  task automatic test_extremes();
    clear_alloc();
    frame_alloc_l[0] = 14;
    frame_alloc_r[0] = 1;
    frame_alloc_l[31] = 14;
    send_frame(1'b1, 6'd1, 1, 1, -1);
    clear_alloc();
    frame_alloc_l[5] = 1;
    frame_alloc_r[5] = 0;
    frame_alloc_l[31] = 14;
    send_frame(1'b1, 6'd32, 2, 2, -1);
    wait_drained();
  endtask

  // Mono, oversized bound, forbidden allocation, empty frame
  task automatic test_modes();
    clear_alloc();
    frame_alloc_l[3] = 2;
    frame_alloc_l[20] = 15;
    frame_alloc_r[3] = 9;
    send_frame(1'b0, 6'd20, 0, 0, -1);
    clear_alloc();
    frame_alloc_r[7] = 3;
    frame_alloc_l[9] = 15;
    send_frame(1'b1, 6'd63, 0, 0, -1);
    clear_alloc();
    send_frame(1'b1, 6'd0, 0, 0, -1);
    wait_drained();
  endtask

  // Data while idle, and a frame abandoned by a new start
  task automatic test_noise();
    send_word(afdq_pkg::CMD_DATA, 1'b1, 6'd63, 32'hFFFF_FFFF);
    send_word(afdq_pkg::CMD_DATA, 1'b0, 6'd0, 32'h0000_0000);
    clear_alloc();
    frame_alloc_l[2] = 4;
    send_frame(1'b1, 6'd4, 0, 0, 5);
    send_frame(1'b0, 6'd0, 0, 0, -1);
    wait_drained();
  endtask

  function automatic void random_alloc();
    int r;
    r = $urandom_range(0, 19);
    for (int i = 0; i < 32; i++) begin
      frame_alloc_l[i] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
      frame_alloc_r[i] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
      if (r == 0) begin
        frame_alloc_l[i] = 0;
        frame_alloc_r[i] = 0;
      end
    end
  endfunction

  function automatic logic [5:0] random_bound();
    case ($urandom_range(0, 3))
      0:       return 6'd32;
      1:       return 6'($urandom_range(33, 63));
      default: return 6'($urandom_range(0, 31));
    endcase
  endfunction

  // Long receiver hold-off with the sender still offering, then a full drain
  task automatic test_backpressure();
    no_idle = 1'b1;
    stall_hold = 400;
    random_alloc();
    frame_alloc_l[0] = 6;
    send_frame(1'b1, random_bound(), 0, 0, -1);
    random_alloc();
    send_frame(1'b1, random_bound(), 0, 0, -1);
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Mostly whole frames with random content, some noise and cut frames
  task automatic test_random(input int word_budget);
    int stop_at, r;
    stop_at = words_sent + word_budget;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 9) == 0);
      random_alloc();
      if (r < 8) send_word(afdq_pkg::CMD_DATA, 1'($urandom), 6'($urandom), $urandom);
      else if (r < 15) send_frame(1'($urandom), random_bound(), 0, 0, $urandom_range(0, 6));
      else send_frame(1'($urandom), random_bound(), 0, 0, -1);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.command = afdq_pkg::CMD_START;
    in_if.stereo = 1'b0;
    in_if.bound = '0;
    in_if.word = '0;
    pr_phase = 0;
    pr_pos = 0;
    words_sent = 0;
    frames_sent = 0;
    pairs_checked = 0;
    mismatches = 0;
    no_idle = 1'b0;
    for (int i = 0; i < 64; i++) begin
      pr_alloc[i] = '0;
      pr_scidx[i] = '0;
    end
    @(posedge rst_n);
    @(posedge clk);
    test_extremes();
    test_modes();
    test_noise();
    test_backpressure();
    test_random(250);
    repeat (30) @(posedge clk);
    $display("Covered %0d input words, %0d frame starts, %0d sample pairs checked.",
             words_sent, frames_sent, pairs_checked);
    $display("Mono/stereo, all bound ranges, forbidden and empty allocations, cut frames.");
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ audio_layer1_frame_dequantizer_unit.f @@
+incdir+hw/rtl
hw/rtl/afdq_pkg.sv
hw/rtl/afdq_channels.sv
hw/rtl/afdq_ram.sv
hw/rtl/afdq_ctrl.sv
hw/rtl/afdq_dp.sv
hw/rtl/audio_layer1_frame_dequantizer_unit.sv
dv/tb_top.sv
